@@ rtl/mtf_pkg.sv @@
package mtf_pkg;

  // Field widths of the request and response payloads
  localparam int CMD_W = 2;
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int ST_W  = 2;

  // Request opcodes; the fourth code is unused and rejected
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_MOVE   = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_e;

  // Response status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_EMPTY  = 2'd2
  } status_e;

  // Read address source for the list memory
  typedef enum logic [2:0] {
    RD_POS     = 3'd0,
    RD_ZERO    = 3'd1,
    RD_IDX_DN1 = 3'd2,
    RD_IDX_DN2 = 3'd3,
    RD_IDX_UP1 = 3'd4
  } rd_sel_e;

  // Update of the walk index
  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_POS  = 3'd1,
    IDX_ZERO = 3'd2,
    IDX_DEC  = 3'd3,
    IDX_INC  = 3'd4
  } idx_op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    accept;
    logic    rd_en;
    rd_sel_e rd_sel;
    idx_op_e idx_op;
    logic    grab;
    logic    shift_wr;
    logic    head_wr;
    logic    emit_rsp;
    logic    emit_elem;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_ok;
    logic pos_one;
    logic idx_one;
    logic idx_last;
    logic out_free;
  } ctl_sts_t;

endpackage

@@ rtl/mtf_req_if.sv @@
interface mtf_req_if;
  logic                                valid;
  logic                                ready;
  logic [mtf_pkg::CMD_W-1:0]           cmd;
  logic signed [mtf_pkg::VAL_W-1:0]    value;
  logic [mtf_pkg::POS_W-1:0]           position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink   (input valid, cmd, value, position, output ready);
endinterface

@@ rtl/mtf_rsp_if.sv @@
interface mtf_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [mtf_pkg::ST_W-1:0]            status;
  logic signed [mtf_pkg::VAL_W-1:0]    element;
  logic                                last;

  modport source (output valid, status, element, last, input ready);
  modport sink   (input valid, status, element, last, output ready);
endinterface

@@ rtl/mtf_ctrl.sv @@
module mtf_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mtf_pkg::CMD_W-1:0] in_cmd,
  input  mtf_pkg::ctl_sts_t         sts,
  output mtf_pkg::ctl_cmd_t         ctl
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_MV_GRAB  = 6'b000010,
    S_MV_SHIFT = 6'b000100,
    S_MV_HEAD  = 6'b001000,
    S_RESP     = 6'b010000,
    S_DUMP_OUT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  // no request is taken while reset is held
  assign in_ready = (state == S_IDLE) && !rst;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing of the commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.accept = 1'b1;
          if (mtf_pkg::cmd_e'(in_cmd) == mtf_pkg::CMD_MOVE && sts.pos_ok && !sts.pos_one) begin
            // fetch the element being moved
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = mtf_pkg::RD_POS;
            ctl.idx_op = mtf_pkg::IDX_POS;
            state_next = S_MV_GRAB;
          end else if (mtf_pkg::cmd_e'(in_cmd) == mtf_pkg::CMD_DUMP && !sts.empty) begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = mtf_pkg::RD_ZERO;
            ctl.idx_op = mtf_pkg::IDX_ZERO;
            state_next = S_DUMP_OUT;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_MV_GRAB: begin
        ctl.grab   = 1'b1;
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = mtf_pkg::RD_IDX_DN1;
        state_next = S_MV_SHIFT;
      end
      S_MV_SHIFT: begin
        // entry idx-1 moves back into idx, next read two below
        ctl.shift_wr = 1'b1;
        ctl.idx_op   = mtf_pkg::IDX_DEC;
        if (sts.idx_one) begin
          state_next = S_MV_HEAD;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = mtf_pkg::RD_IDX_DN2;
        end
      end
      S_MV_HEAD: begin
        ctl.head_wr = 1'b1;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          ctl.emit_rsp = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DUMP_OUT: begin
        if (sts.out_free) begin
          ctl.emit_elem = 1'b1;
          if (sts.idx_last) begin
            state_next = S_IDLE;
          end else begin
            ctl.rd_en  = 1'b1;
            ctl.rd_sel = mtf_pkg::RD_IDX_UP1;
            ctl.idx_op = mtf_pkg::IDX_INC;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/mtf_dpath.sv @@
module mtf_dpath #(
  parameter int DEPTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mtf_pkg::ctl_cmd_t                ctl,
  output mtf_pkg::ctl_sts_t                sts,
  input  logic [mtf_pkg::CMD_W-1:0]        in_cmd,
  input  logic signed [mtf_pkg::VAL_W-1:0] in_value,
  input  logic [mtf_pkg::POS_W-1:0]        in_position,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [mtf_pkg::ST_W-1:0]         out_status,
  output logic signed [mtf_pkg::VAL_W-1:0] out_element,
  output logic                             out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > mtf_pkg::POS_W) ? CW : mtf_pkg::POS_W;

  logic signed [mtf_pkg::VAL_W-1:0] mem [DEPTH];
  logic signed [mtf_pkg::VAL_W-1:0] rdata;
  logic signed [mtf_pkg::VAL_W-1:0] moved;
  logic [CW-1:0]                    count;
  logic [AW-1:0]                    idx;
  logic [AW-1:0]                    idx_next;
  mtf_pkg::status_e                 rsp_status;

  logic [XW-1:0]                    pos_x;
  logic [XW-1:0]                    cnt_x;
  logic [AW-1:0]                    pos_addr;
  logic [AW-1:0]                    rd_addr;
  logic                             append_wr;
  logic                             we;
  logic [AW-1:0]                    wa;
  logic signed [mtf_pkg::VAL_W-1:0] wd;
  logic                             emit;

  // Request decode and status
  assign pos_x        = XW'(in_position);
  assign cnt_x        = XW'(count);
  assign pos_addr     = AW'(pos_x - XW'(1));
  assign sts.full     = (count == CW'(DEPTH));
  assign sts.empty    = (count == '0);
  assign sts.pos_ok   = (in_position != '0) && (pos_x <= cnt_x);
  assign sts.pos_one  = (in_position == mtf_pkg::POS_W'(1));
  assign sts.idx_one  = (idx == AW'(1));
  assign sts.idx_last = ((CW'(idx) + CW'(1)) == count);
  assign sts.out_free = !out_valid || out_ready;

  assign append_wr = ctl.accept && (mtf_pkg::cmd_e'(in_cmd) == mtf_pkg::CMD_APPEND) && !sts.full;
  assign emit      = ctl.emit_rsp || ctl.emit_elem;

  // Read address select
  always_comb begin
    case (ctl.rd_sel)
      mtf_pkg::RD_POS:     rd_addr = pos_addr;
      mtf_pkg::RD_ZERO:    rd_addr = '0;
      mtf_pkg::RD_IDX_DN1: rd_addr = idx - AW'(1);
      mtf_pkg::RD_IDX_DN2: rd_addr = idx - AW'(2);
      mtf_pkg::RD_IDX_UP1: rd_addr = idx + AW'(1);
      default:             rd_addr = '0;
    endcase
  end

  // Walk index update
  always_comb begin
    case (ctl.idx_op)
      mtf_pkg::IDX_HOLD: idx_next = idx;
      mtf_pkg::IDX_POS:  idx_next = pos_addr;
      mtf_pkg::IDX_ZERO: idx_next = '0;
      mtf_pkg::IDX_DEC:  idx_next = idx - AW'(1);
      mtf_pkg::IDX_INC:  idx_next = idx + AW'(1);
      default:           idx_next = idx;
    endcase
  end

  // Single write port: append at tail, shift back, or moved element at head
  assign we = append_wr || ctl.shift_wr || ctl.head_wr;
  assign wa = append_wr ? count[AW-1:0] : (ctl.shift_wr ? idx : '0);
  assign wd = append_wr ? in_value : (ctl.shift_wr ? rdata : moved);

  // List memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (ctl.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (ctl.grab) begin
      moved <= rdata;
    end
  end

  // Element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (append_wr) begin
      count <= count + CW'(1);
    end
  end

  // Status of single-result requests, fixed at acceptance
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      case (mtf_pkg::cmd_e'(in_cmd))
        mtf_pkg::CMD_APPEND: rsp_status <= sts.full ? mtf_pkg::ST_REJECT : mtf_pkg::ST_OK;
        mtf_pkg::CMD_MOVE:   rsp_status <= sts.pos_ok ? mtf_pkg::ST_OK : mtf_pkg::ST_REJECT;
        mtf_pkg::CMD_DUMP:   rsp_status <= mtf_pkg::ST_EMPTY;
        default:             rsp_status <= mtf_pkg::ST_REJECT;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_rsp) begin
      out_status  <= rsp_status;
      out_element <= '0;
      out_last    <= 1'b1;
    end else if (ctl.emit_elem) begin
      out_status  <= mtf_pkg::ST_OK;
      out_element <= rdata;
      out_last    <= sts.idx_last;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count above depth");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> sts.out_free)
    else $error("response loaded over an unread response");

  a_one_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0({append_wr, ctl.shift_wr, ctl.head_wr}))
    else $error("write port conflict");

  a_shift_idx: assert property (@(posedge clk) disable iff (rst)
    ctl.shift_wr |-> (idx != '0))
    else $error("shift into the head slot");

  a_count_append: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> $past(append_wr))
    else $error("count changed without an append");

endmodule

@@ rtl/move_to_front_list_core.sv @@
// Move-to-front list of up to DEPTH signed 32-bit values.
//
// req (sink): cmd, value, position. A request is taken when valid and ready
// are both high. Append puts value at the tail; move takes the element at
// 1-based position to the head; dump reads the whole list head to tail.
// rsp (source): status, element, last. Every request gives one response
// with last set, except a dump of a non-empty list, which gives one response
// per element with last on the tail element.
//
// One request is in work at a time; ready is high only between requests.
// Append, rejected requests, move of position one and dump of an empty list:
// status fixed at acceptance, loaded into the response register once it is
// free, then ready is high again. Move of position p >= 2: the element is
// read and grabbed, one memory entry is shifted per cycle through the single
// read and single write port, and the grabbed element goes to the head.
// Dump: one element per cycle from the registered read while not stalled.
// The response is held in an output register; a stalled receiver holds the
// sequence in place and the next request is still taken while the last
// response waits. Reset clears the element count and the control state;
// the list memory is not cleared and needs no clearing pass.
module move_to_front_list_core #(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  mtf_req_if.sink   req,
  mtf_rsp_if.source rsp
);

  mtf_pkg::ctl_cmd_t ctl;
  mtf_pkg::ctl_sts_t sts;

  mtf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .in_cmd   (req.cmd),
    .sts      (sts),
    .ctl      (ctl)
  );

  mtf_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .in_cmd      (req.cmd),
    .in_value    (req.value),
    .in_position (req.position),
    .out_ready   (rsp.ready),
    .out_valid   (rsp.valid),
    .out_status  (rsp.status),
    .out_element (rsp.element),
    .out_last    (rsp.last)
  );

endmodule

@@ bench/move_to_front_list_core_tb.sv @@
module move_to_front_list_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = 32;
  localparam int RANDOM_ITEMS = 365;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;

  // Fourth opcode has no enum member; the block rejects it
  localparam logic [mtf_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [mtf_pkg::CMD_W-1:0]        cmd;
    logic signed [mtf_pkg::VAL_W-1:0] value;
    logic [mtf_pkg::POS_W-1:0]        position;
  } list_req_t;

  typedef struct {
    mtf_pkg::status_e                 status;
    logic signed [mtf_pkg::VAL_W-1:0] element;
    logic                             last;
  } list_rsp_t;

  logic clk;
  logic rst;

  mtf_req_if req_if ();
  mtf_rsp_if rsp_if ();

  move_to_front_list_core #(
    .DEPTH(LIST_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // Request queue fed by the stimulus, responses awaited by the checker
  list_req_t pending_reqs[$];
  list_rsp_t awaited_rsps[$];

  // Mirror of the list contents
  logic signed [mtf_pkg::VAL_W-1:0] mirror_list[LIST_DEPTH];
  int mirror_count = 0;

  int gen_count   = 0;
  int n_accepted  = 0;
  int n_errors    = 0;
  int hold_left   = 0;
  int holds_done  = 0;
  int cycle_count = 0;

  // Clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Known input values from time zero
  initial begin
    req_if.valid    = 1'b0;
    req_if.cmd      = mtf_pkg::CMD_DUMP;
    req_if.value    = '0;
    req_if.position = '0;
    rsp_if.ready    = 1'b0;
  end

  function automatic void push_rsp(mtf_pkg::status_e status,
                                   logic signed [mtf_pkg::VAL_W-1:0] element,
                                   logic last);
    list_rsp_t r;
    r.status  = status;
    r.element = element;
    r.last    = last;
    awaited_rsps.push_back(r);
  endfunction

  // Applies one request to the mirror list and queues its responses
  function automatic void predict_list_op(logic [mtf_pkg::CMD_W-1:0] cmd,
                                          logic signed [mtf_pkg::VAL_W-1:0] value,
                                          logic [mtf_pkg::POS_W-1:0] position);
    logic signed [mtf_pkg::VAL_W-1:0] moved;
    case (cmd)
      mtf_pkg::CMD_APPEND: begin
        if (mirror_count >= LIST_DEPTH) begin
          push_rsp(mtf_pkg::ST_REJECT, '0, 1'b1);
        end else begin
          mirror_list[mirror_count] = value;
          mirror_count++;
          push_rsp(mtf_pkg::ST_OK, '0, 1'b1);
        end
      end
      mtf_pkg::CMD_MOVE: begin
        if (position == 0 || int'(position) > mirror_count) begin
          push_rsp(mtf_pkg::ST_REJECT, '0, 1'b1);
        end else begin
          moved = mirror_list[position - 1];
          for (int i = int'(position) - 1; i > 0; i--) mirror_list[i] = mirror_list[i - 1];
          mirror_list[0] = moved;
          push_rsp(mtf_pkg::ST_OK, '0, 1'b1);
        end
      end
      mtf_pkg::CMD_DUMP: begin
        if (mirror_count == 0) begin
          push_rsp(mtf_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < mirror_count; i++)
            push_rsp(mtf_pkg::ST_OK, mirror_list[i], i == mirror_count - 1);
        end
      end
      default: push_rsp(mtf_pkg::ST_REJECT, '0, 1'b1);
    endcase
  endfunction

  // Queues a request and tracks the list length it leads to
  function automatic void add_req(logic [mtf_pkg::CMD_W-1:0] cmd,
                                  logic signed [mtf_pkg::VAL_W-1:0] value,
                                  logic [mtf_pkg::POS_W-1:0] position);
    list_req_t r;
    r.cmd      = cmd;
    r.value    = value;
    r.position = position;
    pending_reqs.push_back(r);
    if (cmd == mtf_pkg::CMD_APPEND && gen_count < LIST_DEPTH) gen_count++;
  endfunction

  function automatic logic signed [mtf_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [mtf_pkg::POS_W-1:0] rand_pos();
    return mtf_pkg::POS_W'($urandom);
  endfunction

  // Position past the count, or zero
  function automatic logic [mtf_pkg::POS_W-1:0] bad_position();
    if ($urandom_range(3) == 0) return '0;
    return mtf_pkg::POS_W'($urandom_range(63, gen_count + 1));
  endfunction

  function automatic logic [mtf_pkg::POS_W-1:0] good_position();
    case ($urandom_range(9))
      0:       return mtf_pkg::POS_W'(1);
      1:       return mtf_pkg::POS_W'(gen_count);
      default: return mtf_pkg::POS_W'($urandom_range(gen_count, 1));
    endcase
  endfunction

  function automatic bit no_idle_window();
    return n_accepted >= 150 && n_accepted < 230;
  endfunction

  // Request driver: holds valid until taken, then offers the next request
  always @(posedge clk) begin : req_driver
    list_req_t nxt;
    bit        fire;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      fire = req_if.valid && req_if.ready;
      if (fire) begin
        predict_list_op(req_if.cmd, req_if.value, req_if.position);
        n_accepted <= n_accepted + 1;
      end
      if (!req_if.valid || fire) begin
        if (pending_reqs.size() > 0 && (no_idle_window() || $urandom_range(99) >= 33)) begin
          nxt = pending_reqs.pop_front();
          req_if.valid    <= 1'b1;
          req_if.cmd      <= nxt.cmd;
          req_if.value    <= nxt.value;
          req_if.position <= nxt.position;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and receiver backpressure
  always @(posedge clk) begin : rsp_monitor
    list_rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (awaited_rsps.size() == 0) begin
        $error("unexpected response: status=%0d element=%0d last=%0d",
               rsp_if.status, rsp_if.element, rsp_if.last);
        n_errors++;
      end else begin
        want = awaited_rsps.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, rsp_if.status);
          n_errors++;
        end
        if (rsp_if.element !== want.element) begin
          $error("element mismatch: expected %0d, got %0d", want.element, rsp_if.element);
          n_errors++;
        end
        if (rsp_if.last !== want.last) begin
          $error("last mismatch: expected %0d, got %0d", want.last, rsp_if.last);
          n_errors++;
        end
      end
    end

    // Long hold-offs let the block back up and stall its input
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if ((holds_done == 0 && n_accepted >= 60) ||
                 (holds_done == 1 && n_accepted >= 300)) begin
      rsp_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      holds_done   <= holds_done + 1;
    end else begin
      rsp_if.ready <= no_idle_window() || $urandom_range(99) >= 33;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int roll;

    // Empty list: dump, moves and the unused opcode are all rejected or empty
    add_req(mtf_pkg::CMD_DUMP, '0, '0);
    add_req(mtf_pkg::CMD_MOVE, '0, 6'd0);
    add_req(mtf_pkg::CMD_MOVE, '0, 6'd1);
    add_req(CMD_UNUSED, -32'sd1, 6'd63);
    // Extreme values
    add_req(mtf_pkg::CMD_APPEND, 32'sh7FFF_FFFF, 6'd63);
    add_req(mtf_pkg::CMD_APPEND, 32'sh8000_0000, '0);
    add_req(mtf_pkg::CMD_APPEND, '0, '0);
    add_req(mtf_pkg::CMD_APPEND, -32'sd1, 6'd1);
    add_req(mtf_pkg::CMD_DUMP, '0, '0);
    // Move of the head leaves the list as is, tail goes to the head
    add_req(mtf_pkg::CMD_MOVE, '0, 6'd1);
    add_req(mtf_pkg::CMD_MOVE, -32'sd1, 6'd4);
    add_req(mtf_pkg::CMD_DUMP, '0, '0);
    // Past the count and the largest position, then moves of positions two and three
    add_req(mtf_pkg::CMD_MOVE, '0, 6'd5);
    add_req(mtf_pkg::CMD_MOVE, '0, 6'd63);
    add_req(mtf_pkg::CMD_MOVE, '0, 6'd2);
    add_req(mtf_pkg::CMD_MOVE, '0, 6'd3);
    add_req(mtf_pkg::CMD_DUMP, -32'sd1, 6'd63);

    // Random part: fill the list, then mostly moves and dumps on a full list
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      roll = $urandom_range(99);
      if (gen_count < LIST_DEPTH) begin
        if (roll < 50 || (roll < 70 && gen_count == 0))
          add_req(mtf_pkg::CMD_APPEND, pick_value(), rand_pos());
        else if (roll < 70)
          add_req(mtf_pkg::CMD_MOVE, $urandom, good_position());
        else if (roll < 85)
          add_req(mtf_pkg::CMD_DUMP, $urandom, rand_pos());
        else if (roll < 95)
          add_req(mtf_pkg::CMD_MOVE, $urandom, bad_position());
        else
          add_req(CMD_UNUSED, $urandom, rand_pos());
      end else begin
        if (roll < 45)
          add_req(mtf_pkg::CMD_MOVE, $urandom, good_position());
        else if (roll < 65)
          add_req(mtf_pkg::CMD_DUMP, $urandom, rand_pos());
        else if (roll < 80)
          add_req(mtf_pkg::CMD_APPEND, pick_value(), rand_pos());
        else if (roll < 92)
          add_req(mtf_pkg::CMD_MOVE, $urandom, bad_position());
        else
          add_req(CMD_UNUSED, $urandom, rand_pos());
      end
    end

    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_if.valid || awaited_rsps.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mtf_pkg.sv
rtl/mtf_req_if.sv
rtl/mtf_rsp_if.sv
rtl/mtf_ctrl.sv
rtl/mtf_dpath.sv
rtl/move_to_front_list_core.sv
bench/move_to_front_list_core_tb.sv
